@@ sv/segment_intersection_top_defines.svh @@
// Assertion helpers for the asserting RTL file segment_intersection_top.sv.
`ifndef SEGMENT_INTERSECTION_TOP_DEFINES_SVH
`define SEGMENT_INTERSECTION_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SEGINT_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segint assertion failed");

// Next-cycle implication, disabled during reset.
`define SEGINT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segint assertion failed");

`endif

@@ sv/segint_pkg.sv @@
package segint_pkg;

   // Field widths
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 8;
   localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;

   // Internal arithmetic widths
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int DEN_BITS  = PROD_BITS + 1;
   localparam int TRIP_BITS = PROD_BITS + DIFF_BITS;
   localparam int NUM_BITS  = TRIP_BITS + 2;
   localparam int DVD_BITS  = NUM_BITS + FRAC_BITS;
   localparam int QUO_BITS  = OUT_BITS;
   localparam int HIGH_BITS = DVD_BITS - QUO_BITS;
   localparam int REM_BITS  = DEN_BITS + 1;
   localparam int PNT_BITS  = QUO_BITS + 2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax0;
      logic signed [COORD_BITS-1:0] ay0;
      logic signed [COORD_BITS-1:0] ax1;
      logic signed [COORD_BITS-1:0] ay1;
      logic signed [COORD_BITS-1:0] bx0;
      logic signed [COORD_BITS-1:0] by0;
      logic signed [COORD_BITS-1:0] bx1;
      logic signed [COORD_BITS-1:0] by1;
   } seg_pair_type;

   // Operands handed from the front end to the divider
   typedef struct packed {
      seg_pair_type          pair;
      logic [NUM_BITS-1:0]   mag_x;
      logic [NUM_BITS-1:0]   mag_y;
      logic [DEN_BITS-1:0]   den_mag;
      logic                  den_zero;
      logic                  neg_x;
      logic                  neg_y;
   } front_type;

   // One restoring-division lane
   typedef struct packed {
      logic [DEN_BITS-1:0] rem;
      logic [QUO_BITS-1:0] low;
      logic [QUO_BITS-1:0] quo;
   } lane_type;

   typedef struct packed {
      seg_pair_type          pair;
      logic [DEN_BITS-1:0]   den_mag;
      logic                  den_zero;
      logic                  neg_x;
      logic                  neg_y;
      logic                  ovf_x;
      logic                  ovf_y;
      lane_type              x;
      lane_type              y;
   } div_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] cross_x;
      logic signed [OUT_BITS-1:0] cross_y;
      logic                       hit;
   } result_type;

endpackage

@@ sv/segint_front.sv @@
module segint_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  segint_pkg::seg_pair_type in_pair,
   output logic                     out_valid,
   output segint_pkg::front_type    out_data
);

   localparam int CB = segint_pkg::COORD_BITS;
   localparam int DB = segint_pkg::DIFF_BITS;
   localparam int PB = segint_pkg::PROD_BITS;
   localparam int EB = segint_pkg::DEN_BITS;
   localparam int TB = segint_pkg::TRIP_BITS;
   localparam int NB = segint_pkg::NUM_BITS;

   logic [4:0] vld_ff;

   // Stage 1: direction vectors and start offset
   segint_pkg::seg_pair_type s1_pair_ff;
   logic signed [DB-1:0] s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff, s1_dx_ff, s1_dy_ff;
   logic signed [DB-1:0] x1_in, y1_in, x2_in, y2_in, dx_in, dy_in;

   assign x1_in = {in_pair.ax1[CB-1], in_pair.ax1} - {in_pair.ax0[CB-1], in_pair.ax0};
   assign y1_in = {in_pair.ay1[CB-1], in_pair.ay1} - {in_pair.ay0[CB-1], in_pair.ay0};
   assign x2_in = {in_pair.bx1[CB-1], in_pair.bx1} - {in_pair.bx0[CB-1], in_pair.bx0};
   assign y2_in = {in_pair.by1[CB-1], in_pair.by1} - {in_pair.by0[CB-1], in_pair.by0};
   assign dx_in = {in_pair.bx0[CB-1], in_pair.bx0} - {in_pair.ax0[CB-1], in_pair.ax0};
   assign dy_in = {in_pair.by0[CB-1], in_pair.by0} - {in_pair.ay0[CB-1], in_pair.ay0};

   // Stage 2: pairwise products of the direction components
   segint_pkg::seg_pair_type s2_pair_ff;
   logic signed [PB-1:0] s2_xx_ff, s2_yx_ff, s2_xy_ff, s2_yy_ff;
   logic signed [DB-1:0] s2_dx_ff, s2_dy_ff;
   logic signed [PB-1:0] xx_in, yx_in, xy_in, yy_in;

   assign xx_in = s1_x1_ff * s1_x2_ff;
   assign yx_in = s1_y1_ff * s1_x2_ff;
   assign xy_in = s1_x1_ff * s1_y2_ff;
   assign yy_in = s1_y1_ff * s1_y2_ff;

   // Stage 3: denominator and the triple products of both numerators
   segint_pkg::seg_pair_type s3_pair_ff;
   logic signed [EB-1:0] s3_den_ff;
   logic signed [TB-1:0] s3_t0_ff, s3_t1_ff, s3_t2_ff, s3_u0_ff, s3_u1_ff, s3_u2_ff;
   logic signed [EB-1:0] den_in;
   logic signed [TB-1:0] t0_in, t1_in, t2_in, u0_in, u1_in, u2_in;
   logic signed [CB-1:0] ax0_s, ay0_s, bx0_s, by0_s;

   assign ax0_s  = s2_pair_ff.ax0;
   assign ay0_s  = s2_pair_ff.ay0;
   assign bx0_s  = s2_pair_ff.bx0;
   assign by0_s  = s2_pair_ff.by0;
   assign den_in = EB'(s2_yx_ff) - EB'(s2_xy_ff);
   assign t0_in  = s2_xx_ff * s2_dy_ff;
   assign t1_in  = s2_yx_ff * ax0_s;
   assign t2_in  = s2_xy_ff * bx0_s;
   assign u0_in  = s2_yy_ff * s2_dx_ff;
   assign u1_in  = s2_xy_ff * ay0_s;
   assign u2_in  = s2_yx_ff * by0_s;

   // Stage 4: sum the numerators
   segint_pkg::seg_pair_type s4_pair_ff;
   logic signed [EB-1:0] s4_den_ff;
   logic signed [NB-1:0] s4_nx_ff, s4_ny_ff;
   logic signed [NB-1:0] nx_in, ny_in;

   assign nx_in = NB'(s3_t0_ff) + NB'(s3_t1_ff) - NB'(s3_t2_ff);
   assign ny_in = NB'(s3_u2_ff) - NB'(s3_u0_ff) - NB'(s3_u1_ff);

   // Stage 5: split into magnitudes and result signs
   segint_pkg::front_type s5_ff;
   segint_pkg::front_type s5_in;

   always_comb begin
      s5_in.pair     = s4_pair_ff;
      s5_in.mag_x    = s4_nx_ff[NB-1] ? $unsigned(-s4_nx_ff) : $unsigned(s4_nx_ff);
      s5_in.mag_y    = s4_ny_ff[NB-1] ? $unsigned(-s4_ny_ff) : $unsigned(s4_ny_ff);
      s5_in.den_mag  = s4_den_ff[EB-1] ? $unsigned(-s4_den_ff) : $unsigned(s4_den_ff);
      s5_in.den_zero = (s4_den_ff == '0);
      s5_in.neg_x    = s4_nx_ff[NB-1] ^ s4_den_ff[EB-1];
      s5_in.neg_y    = s4_ny_ff[NB-1] ^ s4_den_ff[EB-1];
   end

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   // Advance the payload on every enabled cycle
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pair_ff <= in_pair;
         s1_x1_ff   <= x1_in;
         s1_y1_ff   <= y1_in;
         s1_x2_ff   <= x2_in;
         s1_y2_ff   <= y2_in;
         s1_dx_ff   <= dx_in;
         s1_dy_ff   <= dy_in;

         s2_pair_ff <= s1_pair_ff;
         s2_xx_ff   <= xx_in;
         s2_yx_ff   <= yx_in;
         s2_xy_ff   <= xy_in;
         s2_yy_ff   <= yy_in;
         s2_dx_ff   <= s1_dx_ff;
         s2_dy_ff   <= s1_dy_ff;

         s3_pair_ff <= s2_pair_ff;
         s3_den_ff  <= den_in;
         s3_t0_ff   <= t0_in;
         s3_t1_ff   <= t1_in;
         s3_t2_ff   <= t2_in;
         s3_u0_ff   <= u0_in;
         s3_u1_ff   <= u1_in;
         s3_u2_ff   <= u2_in;

         s4_pair_ff <= s3_pair_ff;
         s4_den_ff  <= s3_den_ff;
         s4_nx_ff   <= nx_in;
         s4_ny_ff   <= ny_in;

         s5_ff      <= s5_in;
      end
   end

   assign out_valid = vld_ff[4];
   assign out_data  = s5_ff;

endmodule

@@ sv/segint_div.sv @@
module segint_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  segint_pkg::front_type in_data,
   output logic                  out_valid,
   output segint_pkg::div_type   out_data
);

   localparam int EB = segint_pkg::DEN_BITS;
   localparam int QB = segint_pkg::QUO_BITS;
   localparam int VB = segint_pkg::DVD_BITS;
   localparam int HB = segint_pkg::HIGH_BITS;
   localparam int RB = segint_pkg::REM_BITS;

   // One restoring step: bring down a dividend bit, subtract if it fits
   function automatic segint_pkg::lane_type div_step(input segint_pkg::lane_type cur,
                                                     input logic [EB-1:0] d);
      logic [RB-1:0]        trial;
      logic [RB-1:0]        diff;
      segint_pkg::lane_type nxt;
      trial   = {cur.rem, cur.low[QB-1]};
      diff    = trial - {1'b0, d};
      nxt.low = cur.low << 1;
      if (trial >= {1'b0, d}) begin
         nxt.rem = diff[EB-1:0];
         nxt.quo = {cur.quo[QB-2:0], 1'b1};
      end else begin
         nxt.rem = trial[EB-1:0];
         nxt.quo = {cur.quo[QB-2:0], 1'b0};
      end
      return nxt;
   endfunction

   logic [QB:0]         vld_ff;
   segint_pkg::div_type stg_ff [0:QB];
   segint_pkg::div_type stg_in [0:QB];

   logic [VB-1:0] dvd_x, dvd_y;
   logic [HB-1:0] high_x, high_y;
   logic          ovf_x, ovf_y;

   // Prepare: scale the numerators and flag quotients that cannot land in a box
   assign dvd_x  = VB'(in_data.mag_x) << segint_pkg::FRAC_BITS;
   assign dvd_y  = VB'(in_data.mag_y) << segint_pkg::FRAC_BITS;
   assign high_x = dvd_x[VB-1:QB];
   assign high_y = dvd_y[VB-1:QB];
   assign ovf_x  = (high_x >= HB'(in_data.den_mag));
   assign ovf_y  = (high_y >= HB'(in_data.den_mag));

   always_comb begin
      stg_in[0].pair     = in_data.pair;
      stg_in[0].den_mag  = in_data.den_mag;
      stg_in[0].den_zero = in_data.den_zero;
      stg_in[0].neg_x    = in_data.neg_x;
      stg_in[0].neg_y    = in_data.neg_y;
      stg_in[0].ovf_x    = ovf_x;
      stg_in[0].ovf_y    = ovf_y;
      stg_in[0].x.rem    = ovf_x ? '0 : high_x[EB-1:0];
      stg_in[0].x.low    = dvd_x[QB-1:0];
      stg_in[0].x.quo    = '0;
      stg_in[0].y.rem    = ovf_y ? '0 : high_y[EB-1:0];
      stg_in[0].y.low    = dvd_y[QB-1:0];
      stg_in[0].y.quo    = '0;
      // One quotient bit per stage for each coordinate
      for (int k = 0; k < QB; k++) begin
         stg_in[k+1]   = stg_ff[k];
         stg_in[k+1].x = div_step(stg_ff[k].x, stg_ff[k].den_mag);
         stg_in[k+1].y = div_step(stg_ff[k].y, stg_ff[k].den_mag);
      end
   end

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QB-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= QB; k++) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign out_valid = vld_ff[QB];
   assign out_data  = stg_ff[QB];

endmodule

@@ sv/segint_box.sv @@
module segint_box (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  segint_pkg::div_type    in_data,
   output logic                   out_valid,
   output segint_pkg::result_type out_data
);

   localparam int CB = segint_pkg::COORD_BITS;
   localparam int QB = segint_pkg::QUO_BITS;
   localparam int PB = segint_pkg::PNT_BITS;
   localparam int OB = segint_pkg::OUT_BITS;

   // Round half away from zero and apply the sign
   function automatic logic signed [PB-1:0] round_point(input segint_pkg::lane_type ln,
                                                        input logic [segint_pkg::DEN_BITS-1:0] d,
                                                        input logic neg);
      logic          up;
      logic [QB:0]   mag;
      logic [PB-1:0] ext;
      up  = ({ln.rem, 1'b0} >= {1'b0, d});
      mag = {1'b0, ln.quo} + (QB+1)'(up);
      ext = PB'(mag);
      return neg ? $signed(PB'(0) - ext) : $signed(ext);
   endfunction

   // Point inside the scaled span of two endpoints, bounds included
   function automatic logic in_span(input logic signed [PB-1:0] p,
                                    input logic signed [CB-1:0] e0,
                                    input logic signed [CB-1:0] e1);
      logic signed [PB-1:0] s0;
      logic signed [PB-1:0] s1;
      logic signed [PB-1:0] lo;
      logic signed [PB-1:0] hi;
      s0 = PB'(e0) <<< segint_pkg::FRAC_BITS;
      s1 = PB'(e1) <<< segint_pkg::FRAC_BITS;
      lo = (s0 < s1) ? s0 : s1;
      hi = (s0 < s1) ? s1 : s0;
      return (p >= lo) && (p <= hi);
   endfunction

   logic                     vld_ff;
   logic signed [PB-1:0]     px_ff, py_ff, px_in, py_in;
   logic                     miss_ff, miss_in;
   segint_pkg::seg_pair_type pair_ff;
   logic                     hit;

   assign px_in   = round_point(in_data.x, in_data.den_mag, in_data.neg_x);
   assign py_in   = round_point(in_data.y, in_data.den_mag, in_data.neg_y);
   assign miss_in = in_data.den_zero | in_data.ovf_x | in_data.ovf_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         miss_ff <= miss_in;
         pair_ff <= in_data.pair;
      end
   end

   // Test the rounded point against both bounding boxes
   assign hit = !miss_ff &&
                in_span(px_ff, pair_ff.ax0, pair_ff.ax1) &&
                in_span(py_ff, pair_ff.ay0, pair_ff.ay1) &&
                in_span(px_ff, pair_ff.bx0, pair_ff.bx1) &&
                in_span(py_ff, pair_ff.by0, pair_ff.by1);

   assign out_valid        = vld_ff;
   assign out_data.hit     = hit;
   assign out_data.cross_x = hit ? px_ff[OB-1:0] : '0;
   assign out_data.cross_y = hit ? py_ff[OB-1:0] : '0;

endmodule

@@ sv/segment_intersection_top.sv @@
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall  segment endpoints a_* and b_*
// rsp       out        rsp_valid/rsp_stall  rsp_cross_x, rsp_cross_y, rsp_hit
//
// One transaction enters per cycle while req_stall is low; a result passes through
// 5 front-end stages, QUO_BITS+1 divider stages, rounding and the output register.
// The divider retires one quotient bit per stage for x and y side by side.
// Reset is synchronous and clears only the valid bits.
// A two-entry output (register plus skid) absorbs rsp_stall; req_stall is
// registered and rises only when the skid entry is occupied.
`include "segment_intersection_top_defines.svh"

module segment_intersection_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_a_start_x,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_a_start_y,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_a_end_x,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_a_end_y,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_b_start_x,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_b_start_y,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_b_end_x,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_b_end_y,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [segint_pkg::OUT_BITS-1:0]   rsp_cross_x,
   output logic signed [segint_pkg::OUT_BITS-1:0]   rsp_cross_y,
   output logic                                     rsp_hit
);

   logic                     adv;
   segint_pkg::seg_pair_type req_pair;
   logic                     front_valid;
   segint_pkg::front_type    front_data;
   logic                     div_valid;
   segint_pkg::div_type      div_data;
   logic                     box_valid;
   segint_pkg::result_type   box_data;

   logic                   rsp_valid_ff, rsp_valid_in;
   segint_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                   skid_valid_ff, skid_valid_in;
   segint_pkg::result_type skid_data_ff, skid_data_in;
   logic                   rsp_take;
   logic                   arrive;
   logic                   rsp_miss;
   logic                   rsp_origin;

   // Freeze the pipeline only while the skid entry is occupied
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign req_pair.ax0 = req_a_start_x;
   assign req_pair.ay0 = req_a_start_y;
   assign req_pair.ax1 = req_a_end_x;
   assign req_pair.ay1 = req_a_end_y;
   assign req_pair.bx0 = req_b_start_x;
   assign req_pair.by0 = req_b_start_y;
   assign req_pair.bx1 = req_b_end_x;
   assign req_pair.by1 = req_b_end_y;

   segint_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_pair   (req_pair),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   segint_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   segint_box u_box (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (box_valid),
      .out_data  (box_data)
   );

   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign arrive   = box_valid && adv;

   // Steer results into the output register or the skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (arrive) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = box_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = box_data;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_cross_x = rsp_data_ff.cross_x;
   assign rsp_cross_y = rsp_data_ff.cross_y;
   assign rsp_hit     = rsp_data_ff.hit;

   assign rsp_miss   = rsp_valid_ff && !rsp_data_ff.hit;
   assign rsp_origin = (rsp_data_ff.cross_x == '0) && (rsp_data_ff.cross_y == '0);

   // The skid entry is only ever filled behind a waiting output transaction
   `SEGINT_ASSERT_IMPL(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff)
   // A full skid entry freezes the last pipeline stage
   `SEGINT_ASSERT_NEXT(a_full_holds_pipe, clock, reset, skid_valid_ff, $stable(box_valid))
   // A miss always reports the origin
   `SEGINT_ASSERT_IMPL(a_miss_is_origin, clock, reset, rsp_miss, rsp_origin)

endmodule
